// ===== sv/stepped_gain_pot_controller_top_assert.svh =====
// Assertion macros for the stepped gain pot controller.
// Used by stepped_gain_pot_controller_top; expects i_clk and i_rst_n in scope.
`ifndef STEPPED_GAIN_POT_CONTROLLER_TOP_ASSERT_SVH
`define STEPPED_GAIN_POT_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define SGPC_ASSERT_IMP(LBL, ANT, CON) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |-> (CON)) \
        else $error("sgpc: same-cycle check failed");

// next-cycle implication
`define SGPC_ASSERT_NXT(LBL, ANT, CON) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ANT) |=> (CON)) \
        else $error("sgpc: next-cycle check failed");

`endif

// ===== sv/sgpc_pkg.sv =====
// Shared types, codes and constants of the stepped gain pot controller.
// No dependencies.
package sgpc_pkg;

    localparam int MV_W    = 13;
    localparam int LEVEL_W = 14;
    localparam int WORD_W  = 14;
    localparam int IDX_W   = 3;

    localparam int unsigned WIPER_TOP_DEF = 16383;
    localparam int unsigned WIPER_RESET   = 'h67;
    localparam int unsigned WIPER_MIN     = 2;
    localparam int unsigned SCALE_Q15     = 51472;

    localparam logic [1:0] MODE_LADDER = 2'd1;
    localparam logic [1:0] MODE_FINE   = 2'd2;
    localparam logic [1:0] MODE_NARROW = 2'd3;

    localparam logic [1:0] GEAR_MIN   = 2'd0;
    localparam logic [1:0] GEAR_MAX   = 2'd3;
    localparam logic [1:0] GEAR_RESET = 2'd3;

    typedef enum logic [1:0] {
        KEY_NONE   = 2'd0,
        KEY_SCALE  = 2'd1,
        KEY_MODE   = 2'd2,
        KEY_IGNORE = 2'd3
    } t_key;

    typedef enum logic [IDX_W-1:0] {
        CFG_LADDER_HIGH = 3'd0,
        CFG_LADDER_LOW  = 3'd1,
        CFG_FINE_REF    = 3'd2,
        CFG_FINE_BAND   = 3'd3,
        CFG_NARROW_REF  = 3'd4,
        CFG_NARROW_BAND = 3'd5
    } t_cfg_idx;

    localparam logic [MV_W-1:0] LADDER_HIGH_RST = 13'd2000;
    localparam logic [MV_W-1:0] LADDER_LOW_RST  = 13'd500;
    localparam logic [MV_W-1:0] FINE_REF_RST    = 13'd1000;
    localparam logic [MV_W-1:0] FINE_BAND_RST   = 13'd200;
    localparam logic [MV_W-1:0] NARROW_REF_RST  = 13'd500;
    localparam logic [MV_W-1:0] NARROW_BAND_RST = 13'd100;

    typedef struct packed {
        logic [MV_W-1:0] ladder_high;
        logic [MV_W-1:0] ladder_low;
        logic [MV_W-1:0] fine_ref;
        logic [MV_W-1:0] fine_band;
        logic [MV_W-1:0] narrow_ref;
        logic [MV_W-1:0] narrow_band;
    } t_cfg;

    typedef struct packed {
        logic [1:0] mode;
        logic       scale;
        logic [1:0] gear;
    } t_ctrl;

    function automatic logic [WORD_W-1:0] gear_word(input logic [1:0] gear);
        logic [WORD_W-1:0] w;
        case (gear)
            2'd0:    w = 14'h0014;
            2'd1:    w = 14'h0033;
            2'd2:    w = 14'h00CD;
            default: w = 14'h0200;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/sgpc_cfg.sv =====
// Configuration register bank for the stepped gain pot controller.
// Depends on sgpc_pkg.
module sgpc_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sgpc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [sgpc_pkg::MV_W-1:0]      i_cfg_data,
    output sgpc_pkg::t_cfg                 o_cfg
);

    sgpc_pkg::t_cfg r_cfg;
    sgpc_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (sgpc_pkg::t_cfg_idx'(i_cfg_index))
                sgpc_pkg::CFG_LADDER_HIGH: n_cfg.ladder_high = i_cfg_data;
                sgpc_pkg::CFG_LADDER_LOW:  n_cfg.ladder_low  = i_cfg_data;
                sgpc_pkg::CFG_FINE_REF:    n_cfg.fine_ref    = i_cfg_data;
                sgpc_pkg::CFG_FINE_BAND:   n_cfg.fine_band   = i_cfg_data;
                sgpc_pkg::CFG_NARROW_REF:  n_cfg.narrow_ref  = i_cfg_data;
                sgpc_pkg::CFG_NARROW_BAND: n_cfg.narrow_band = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ladder_high <= sgpc_pkg::LADDER_HIGH_RST;
            r_cfg.ladder_low  <= sgpc_pkg::LADDER_LOW_RST;
            r_cfg.fine_ref    <= sgpc_pkg::FINE_REF_RST;
            r_cfg.fine_band   <= sgpc_pkg::FINE_BAND_RST;
            r_cfg.narrow_ref  <= sgpc_pkg::NARROW_REF_RST;
            r_cfg.narrow_band <= sgpc_pkg::NARROW_BAND_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ===== sv/sgpc_step.sv =====
// Per-item next-state and result logic: key handling, pi/2 scaling,
// gear ladder and deadband wiper loop. Depends on sgpc_pkg.
module sgpc_step #(
    parameter int unsigned WIPER_TOP = sgpc_pkg::WIPER_TOP_DEF,
    parameter int          WIPER_W   = $clog2(WIPER_TOP + 1)
) (
    input  logic [1:0]                          i_key,
    input  logic signed [sgpc_pkg::LEVEL_W-1:0] i_level,
    input  sgpc_pkg::t_cfg                      i_cfg,
    input  sgpc_pkg::t_ctrl                     i_ctrl,
    input  logic [WIPER_W-1:0]                  i_wiper,
    output sgpc_pkg::t_ctrl                     o_ctrl,
    output logic [WIPER_W-1:0]                  o_wiper,
    output logic                                o_wr,
    output logic [sgpc_pkg::WORD_W-1:0]         o_word
);

    localparam int PROD_W = 31;
    localparam int CMP_W  = 16;
    localparam logic signed [PROD_W-1:0] SCALE_S = PROD_W'(sgpc_pkg::SCALE_Q15);
    localparam logic [WIPER_W-1:0] WMIN = WIPER_W'(sgpc_pkg::WIPER_MIN);
    localparam logic [WIPER_W:0]   WTOP = (WIPER_W + 1)'(WIPER_TOP);

    sgpc_pkg::t_ctrl            ctrl_k;
    logic signed [PROD_W-1:0]   lvl_ext;
    logic signed [PROD_W-1:0]   prod;
    logic signed [CMP_W-1:0]    lvl;
    logic signed [CMP_W-1:0]    ref_mv;
    logic signed [CMP_W-1:0]    band;
    logic signed [CMP_W-1:0]    diff;
    logic [WIPER_W:0]           wiper_inc;

    always_comb begin
        ctrl_k = i_ctrl;
        case (sgpc_pkg::t_key'(i_key))
            sgpc_pkg::KEY_SCALE: ctrl_k.scale = ~i_ctrl.scale;
            sgpc_pkg::KEY_MODE: begin
                if (i_ctrl.mode == sgpc_pkg::MODE_NARROW || i_ctrl.mode == 2'd0)
                    ctrl_k.mode = sgpc_pkg::MODE_LADDER;
                else
                    ctrl_k.mode = i_ctrl.mode + 2'd1;
            end
            default: ;
        endcase
    end

    // floor(mv * pi/2) in Q15; product magnitude stays below 2^29
    assign lvl_ext = PROD_W'(i_level);
    assign prod    = lvl_ext * SCALE_S;
    assign lvl     = ctrl_k.scale ? CMP_W'(signed'(prod[29:15])) : CMP_W'(i_level);

    always_comb begin
        if (ctrl_k.mode == sgpc_pkg::MODE_FINE) begin
            ref_mv = signed'(CMP_W'(i_cfg.fine_ref));
            band   = signed'(CMP_W'(i_cfg.fine_band));
        end else begin
            ref_mv = signed'(CMP_W'(i_cfg.narrow_ref));
            band   = signed'(CMP_W'(i_cfg.narrow_band));
        end
    end

    assign diff      = lvl - ref_mv;
    assign wiper_inc = {1'b0, i_wiper} + (WIPER_W + 1)'(1);

    always_comb begin
        o_ctrl  = ctrl_k;
        o_wiper = i_wiper;
        o_wr    = 1'b0;
        o_word  = '0;
        if (ctrl_k.mode == sgpc_pkg::MODE_LADDER) begin
            if (lvl > signed'(CMP_W'(i_cfg.ladder_high))) begin
                o_wr   = 1'b1;
                o_word = sgpc_pkg::gear_word(ctrl_k.gear);
                if (ctrl_k.gear != sgpc_pkg::GEAR_MIN)
                    o_ctrl.gear = ctrl_k.gear - 2'd1;
            end else if (lvl < signed'(CMP_W'(i_cfg.ladder_low))) begin
                o_wr   = 1'b1;
                o_word = sgpc_pkg::gear_word(ctrl_k.gear);
                if (ctrl_k.gear != sgpc_pkg::GEAR_MAX)
                    o_ctrl.gear = ctrl_k.gear + 2'd1;
            end
        end else begin
            if (diff > band) begin
                o_wr    = 1'b1;
                o_word  = sgpc_pkg::WORD_W'(i_wiper);
                o_wiper = (i_wiper <= WMIN) ? WMIN : i_wiper - WIPER_W'(1);
            end else if (diff < -band) begin
                o_wr    = 1'b1;
                o_word  = sgpc_pkg::WORD_W'(i_wiper);
                o_wiper = (wiper_inc >= WTOP) ? WIPER_W'(WIPER_TOP - 1)
                                              : wiper_inc[WIPER_W-1:0];
            end
        end
    end

endmodule

// ===== sv/stepped_gain_pot_controller_top.sv =====
// Channel  | Direction | Handshake                  | Payload
// in       | sink      | i_in_valid / o_in_stall    | i_key_event, i_output_level_mv
// out      | source    | o_out_valid / i_out_stall  | o_write_valid .. o_scaling_now
// cfg      | sink      | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the out channel is not stalled; an accepted item goes
// from the input register through one step of logic into the result register.
// Control state updates as the item moves into the result register.
// Synchronous active-low reset restores control state and registers; no clearing pass.
// o_in_stall rises only when the input register holds an item and the result
// register is full and stalled.
// Depends on sgpc_pkg, sgpc_cfg, sgpc_step, stepped_gain_pot_controller_top_assert.svh.
module stepped_gain_pot_controller_top #(
    parameter int unsigned WIPER_TOP = sgpc_pkg::WIPER_TOP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_key_event,
    input  logic signed [sgpc_pkg::LEVEL_W-1:0] i_output_level_mv,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_write_valid,
    output logic [sgpc_pkg::WORD_W-1:0]         o_wiper_word,
    output logic [1:0]                          o_gear_now,
    output logic [1:0]                          o_mode_now,
    output logic                                o_scaling_now,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sgpc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [sgpc_pkg::MV_W-1:0]           i_cfg_data
);

    localparam int WIPER_W = $clog2(WIPER_TOP + 1);

    sgpc_pkg::t_cfg                      cfg;
    sgpc_pkg::t_ctrl                     n_ctrl;
    logic [WIPER_W-1:0]                  n_wiper;
    logic                                n_wr;
    logic [sgpc_pkg::WORD_W-1:0]         n_word;
    logic                                w_adv;

    logic                                r_in_valid;
    logic [1:0]                          r_in_key;
    logic signed [sgpc_pkg::LEVEL_W-1:0] r_in_level;
    sgpc_pkg::t_ctrl                     r_ctrl;
    logic [WIPER_W-1:0]                  r_wiper;
    logic                                r_out_valid;
    logic                                r_out_wr;
    logic [sgpc_pkg::WORD_W-1:0]         r_out_word;
    sgpc_pkg::t_ctrl                     r_out_ctrl;

    sgpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sgpc_step #(
        .WIPER_TOP (WIPER_TOP),
        .WIPER_W   (WIPER_W)
    ) u_step (
        .i_key   (r_in_key),
        .i_level (r_in_level),
        .i_cfg   (cfg),
        .i_ctrl  (r_ctrl),
        .i_wiper (r_wiper),
        .o_ctrl  (n_ctrl),
        .o_wiper (n_wiper),
        .o_wr    (n_wr),
        .o_word  (n_word)
    );

    assign w_adv      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctrl.mode  <= sgpc_pkg::MODE_LADDER;
            r_ctrl.scale <= 1'b1;
            r_ctrl.gear  <= sgpc_pkg::GEAR_RESET;
            r_wiper     <= WIPER_W'(sgpc_pkg::WIPER_RESET);
        end else begin
            if (i_in_valid && !o_in_stall)
                r_in_valid <= 1'b1;
            else if (w_adv)
                r_in_valid <= 1'b0;
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_ctrl      <= n_ctrl;
                r_wiper     <= n_wiper;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_key   <= i_key_event;
            r_in_level <= i_output_level_mv;
        end
        if (w_adv) begin
            r_out_wr   <= n_wr;
            r_out_word <= n_word;
            r_out_ctrl <= n_ctrl;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_write_valid = r_out_wr;
    assign o_wiper_word  = r_out_word;
    assign o_gear_now    = r_out_ctrl.gear;
    assign o_mode_now    = r_out_ctrl.mode;
    assign o_scaling_now = r_out_ctrl.scale;

`include "stepped_gain_pot_controller_top_assert.svh"

    `SGPC_ASSERT_IMP(a_idle_word_zero, r_out_valid && !r_out_wr, r_out_word == '0)
    `SGPC_ASSERT_IMP(a_wiper_floor, 1'b1, r_wiper >= WIPER_W'(sgpc_pkg::WIPER_MIN))
    `SGPC_ASSERT_IMP(a_wiper_ceil, 1'b1, r_wiper < WIPER_W'(WIPER_TOP))
    `SGPC_ASSERT_IMP(a_mode_legal, 1'b1, r_ctrl.mode >= sgpc_pkg::MODE_LADDER)
    `SGPC_ASSERT_NXT(a_state_hold, !w_adv, $stable(r_ctrl) && $stable(r_wiper))
    `SGPC_ASSERT_IMP(a_out_tracks_state, r_out_valid, r_out_ctrl == r_ctrl)

endmodule

// ===== tb/stepped_gain_pot_controller_checker.sv =====
`timescale 1ns / 1ps
// Checker for stepped_gain_pot_controller_top: watches the in, out and cfg channels,
// predicts each result item from its own copy of state and registers, compares fields.
// Depends on sgpc_pkg.
module stepped_gain_pot_controller_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic [1:0]                          i_key_event,
    input  logic signed [sgpc_pkg::LEVEL_W-1:0] i_output_level_mv,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_write_valid,
    input  logic [sgpc_pkg::WORD_W-1:0]         o_wiper_word,
    input  logic [1:0]                          o_gear_now,
    input  logic [1:0]                          o_mode_now,
    input  logic                                o_scaling_now,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [sgpc_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [sgpc_pkg::MV_W-1:0]           i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending_results
);

    typedef struct packed {
        logic                        wr;
        logic [sgpc_pkg::WORD_W-1:0] word;
        logic [1:0]                  gear;
        logic [1:0]                  mode;
        logic                        scale;
    } t_pot_result;

    localparam logic [3:0][sgpc_pkg::WORD_W-1:0] LADDER_WORDS =
        {14'h0200, 14'h00CD, 14'h0033, 14'h0014};

    int high_mv, low_mv, fine_ref_mv, fine_band_mv, narrow_ref_mv, narrow_band_mv;
    logic [1:0]  mode_st;
    logic [1:0]  gear_st;
    logic        scale_st;
    int          wiper_st;
    t_pot_result expected_q[$];

    function automatic t_pot_result predict_pot_step(
        input logic [1:0] key,
        input logic signed [sgpc_pkg::LEVEL_W-1:0] mv);
        t_pot_result r;
        longint      lvl;
        int          ref_mv;
        int          band_mv;
        r = '0;
        if (key == sgpc_pkg::KEY_SCALE) begin
            scale_st = ~scale_st;
        end else if (key == sgpc_pkg::KEY_MODE) begin
            mode_st = (mode_st == sgpc_pkg::MODE_NARROW) ? sgpc_pkg::MODE_LADDER
                                                         : mode_st + 2'd1;
        end
        // pi/2 in Q15, floor toward minus infinity
        lvl = scale_st ? ((longint'(mv) * longint'(sgpc_pkg::SCALE_Q15)) >>> 15)
                       : longint'(mv);
        if (mode_st == sgpc_pkg::MODE_LADDER) begin
            if (lvl > high_mv) begin
                r.wr   = 1'b1;
                r.word = LADDER_WORDS[gear_st];
                if (gear_st != sgpc_pkg::GEAR_MIN) gear_st = gear_st - 2'd1;
            end else if (lvl < low_mv) begin
                r.wr   = 1'b1;
                r.word = LADDER_WORDS[gear_st];
                if (gear_st != sgpc_pkg::GEAR_MAX) gear_st = gear_st + 2'd1;
            end
        end else begin
            ref_mv  = (mode_st == sgpc_pkg::MODE_FINE) ? fine_ref_mv : narrow_ref_mv;
            band_mv = (mode_st == sgpc_pkg::MODE_FINE) ? fine_band_mv : narrow_band_mv;
            if (lvl > ref_mv && (lvl - ref_mv) > band_mv) begin
                r.wr     = 1'b1;
                r.word   = wiper_st[sgpc_pkg::WORD_W-1:0];
                wiper_st = (wiper_st <= int'(sgpc_pkg::WIPER_MIN)) ?
                           int'(sgpc_pkg::WIPER_MIN) : wiper_st - 1;
            end else if (lvl < ref_mv && (ref_mv - lvl) > band_mv) begin
                r.wr     = 1'b1;
                r.word   = wiper_st[sgpc_pkg::WORD_W-1:0];
                wiper_st = wiper_st + 1;
                if (wiper_st >= int'(sgpc_pkg::WIPER_TOP_DEF))
                    wiper_st = int'(sgpc_pkg::WIPER_TOP_DEF) - 1;
            end
        end
        r.gear  = gear_st;
        r.mode  = mode_st;
        r.scale = scale_st;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_pot_result got;
        t_pot_result want;
        if (!i_rst_n) begin
            high_mv        = int'(sgpc_pkg::LADDER_HIGH_RST);
            low_mv         = int'(sgpc_pkg::LADDER_LOW_RST);
            fine_ref_mv    = int'(sgpc_pkg::FINE_REF_RST);
            fine_band_mv   = int'(sgpc_pkg::FINE_BAND_RST);
            narrow_ref_mv  = int'(sgpc_pkg::NARROW_REF_RST);
            narrow_band_mv = int'(sgpc_pkg::NARROW_BAND_RST);
            mode_st        = sgpc_pkg::MODE_LADDER;
            gear_st        = sgpc_pkg::GEAR_RESET;
            scale_st       = 1'b1;
            wiper_st       = int'(sgpc_pkg::WIPER_RESET);
            o_fail_count   = 0;
            expected_q.delete();
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_write_valid, o_wiper_word, o_gear_now, o_mode_now, o_scaling_now};
                if (expected_q.size() == 0) begin
                    $error("result item with no expected item waiting");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("write_valid", int'(want.wr), int'(got.wr));
                    check_field("wiper_word", int'(want.word), int'(got.word));
                    check_field("gear_now", int'(want.gear), int'(got.gear));
                    check_field("mode_now", int'(want.mode), int'(got.mode));
                    check_field("scaling_now", int'(want.scale), int'(got.scale));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    sgpc_pkg::CFG_LADDER_HIGH: high_mv        = int'(i_cfg_data);
                    sgpc_pkg::CFG_LADDER_LOW:  low_mv         = int'(i_cfg_data);
                    sgpc_pkg::CFG_FINE_REF:    fine_ref_mv    = int'(i_cfg_data);
                    sgpc_pkg::CFG_FINE_BAND:   fine_band_mv   = int'(i_cfg_data);
                    sgpc_pkg::CFG_NARROW_REF:  narrow_ref_mv  = int'(i_cfg_data);
                    sgpc_pkg::CFG_NARROW_BAND: narrow_band_mv = int'(i_cfg_data);
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                expected_q.push_back(predict_pot_step(i_key_event, i_output_level_mv));
            end
        end
        o_pending_results = expected_q.size();
    end

endmodule

// ===== tb/stepped_gain_pot_controller_top_tb.sv =====
`timescale 1ns / 1ps
// Top of the stepped_gain_pot_controller_top testbench: clock, reset, register writes,
// directed and random items, receiver stalls and the verdict. Depends on sgpc_pkg and
// stepped_gain_pot_controller_checker.
module stepped_gain_pot_controller_top_tb;

    localparam logic [sgpc_pkg::IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [sgpc_pkg::IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int LEVEL_MAX = 6144;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic [1:0]                          i_key_event;
    logic signed [sgpc_pkg::LEVEL_W-1:0] i_output_level_mv;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic                                o_write_valid;
    logic [sgpc_pkg::WORD_W-1:0]         o_wiper_word;
    logic [1:0]                          o_gear_now;
    logic [1:0]                          o_mode_now;
    logic                                o_scaling_now;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [sgpc_pkg::IDX_W-1:0]          i_cfg_index;
    logic [sgpc_pkg::MV_W-1:0]           i_cfg_data;

    int         fail_count;
    int         pending_results;
    logic [1:0] mode_seen;
    int         thr_mv[6];
    bit         hold_req;
    bit         hold_on;

    stepped_gain_pot_controller_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_key_event(i_key_event), .i_output_level_mv(i_output_level_mv),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_write_valid(o_write_valid), .o_wiper_word(o_wiper_word),
        .o_gear_now(o_gear_now), .o_mode_now(o_mode_now), .o_scaling_now(o_scaling_now),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    stepped_gain_pot_controller_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_key_event(i_key_event), .i_output_level_mv(i_output_level_mv),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_write_valid(o_write_valid), .o_wiper_word(o_wiper_word),
        .o_gear_now(o_gear_now), .o_mode_now(o_mode_now), .o_scaling_now(o_scaling_now),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending_results(pending_results)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_item(input sgpc_pkg::t_key key, input int level_mv);
        @(negedge i_clk);
        i_in_valid        <= 1'b1;
        i_key_event       <= key;
        i_output_level_mv <= sgpc_pkg::LEVEL_W'(level_mv);
        do @(posedge i_clk); while (o_in_stall);
        if (key == sgpc_pkg::KEY_MODE) begin
            mode_seen = (mode_seen == sgpc_pkg::MODE_NARROW) ? sgpc_pkg::MODE_LADDER
                                                             : mode_seen + 2'd1;
        end
    endtask

    task automatic idle_gap(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic write_reg(input logic [sgpc_pkg::IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[sgpc_pkg::MV_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < 6) thr_mv[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_results();
        idle_gap(1);
        while (pending_results != 0) @(negedge i_clk);
    endtask

    // levels mostly land near a threshold or band edge, raw or seen through pi/2
    function automatic int pick_level();
        int target;
        case ($urandom_range(0, 5))
            0: target = thr_mv[sgpc_pkg::CFG_LADDER_HIGH];
            1: target = thr_mv[sgpc_pkg::CFG_LADDER_LOW];
            2: target = thr_mv[sgpc_pkg::CFG_FINE_REF] + thr_mv[sgpc_pkg::CFG_FINE_BAND];
            3: target = thr_mv[sgpc_pkg::CFG_FINE_REF] - thr_mv[sgpc_pkg::CFG_FINE_BAND];
            4: target = thr_mv[sgpc_pkg::CFG_NARROW_REF] + thr_mv[sgpc_pkg::CFG_NARROW_BAND];
            default: target = thr_mv[sgpc_pkg::CFG_NARROW_REF]
                              - thr_mv[sgpc_pkg::CFG_NARROW_BAND];
        endcase
        if ($urandom_range(0, 2) == 0) return int'($urandom_range(0, 2 * LEVEL_MAX)) - LEVEL_MAX;
        if ($urandom_range(0, 1) == 0) target = (target * 20861) >>> 15;
        target = target + int'($urandom_range(0, 8)) - 4;
        if (target > LEVEL_MAX) target = LEVEL_MAX;
        if (target < -LEVEL_MAX) target = -LEVEL_MAX;
        return target;
    endfunction

    function automatic sgpc_pkg::t_key pick_key();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 80) return sgpc_pkg::KEY_NONE;
        if (roll < 87) return sgpc_pkg::KEY_SCALE;
        if (roll < 95) return sgpc_pkg::KEY_MODE;
        return sgpc_pkg::KEY_IGNORE;
    endfunction

    task automatic random_items(input int count, input bit gaps);
        int burst;
        burst = 0;
        repeat (count) begin
            if (gaps && burst == 0) begin
                burst = int'($urandom_range(1, 16));
                if ($urandom_range(0, 3) != 0) idle_gap(int'($urandom_range(1, 6)));
            end
            if (burst > 0) burst--;
            send_item(pick_key(), pick_level());
        end
    endtask

    task automatic set_thresholds(input int hi, input int lo, input int fr, input int fb,
                                  input int nr, input int nb);
        drain_results();
        write_reg(sgpc_pkg::CFG_LADDER_HIGH, hi);
        write_reg(sgpc_pkg::CFG_LADDER_LOW, lo);
        write_reg(sgpc_pkg::CFG_FINE_REF, fr);
        write_reg(sgpc_pkg::CFG_FINE_BAND, fb);
        write_reg(sgpc_pkg::CFG_NARROW_REF, nr);
        write_reg(sgpc_pkg::CFG_NARROW_BAND, nb);
    endtask

    task automatic run_phase(input int count);
        idle_gap(1);
        hold_req = 1'b1;
        wait (hold_on);
        random_items(24, 1'b0);
        random_items(count, 1'b1);
    endtask

    // receiver: random stall segments, plus a long hold on request
    initial begin
        int seg;
        int len;
        i_out_stall = 1'b0;
        hold_on     = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_on = 1'b1;
                repeat (64) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_req = 1'b0;
                hold_on  = 1'b0;
            end else begin
                seg = int'($urandom_range(0, 2));
                len = int'($urandom_range(4, 40));
                repeat (len) begin
                    @(negedge i_clk);
                    case (seg)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 99) < 40);
                        default: i_out_stall <= ~i_out_stall;
                    endcase
                end
            end
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_key_event       = sgpc_pkg::KEY_NONE;
        i_output_level_mv = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = sgpc_pkg::CFG_LADDER_HIGH;
        i_cfg_data        = '0;
        hold_req          = 1'b0;
        mode_seen         = sgpc_pkg::MODE_LADDER;
        thr_mv = '{int'(sgpc_pkg::LADDER_HIGH_RST), int'(sgpc_pkg::LADDER_LOW_RST),
                   int'(sgpc_pkg::FINE_REF_RST), int'(sgpc_pkg::FINE_BAND_RST),
                   int'(sgpc_pkg::NARROW_REF_RST), int'(sgpc_pkg::NARROW_BAND_RST)};
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // gear ladder down to its floor and back up to its ceiling
        repeat (4) send_item(sgpc_pkg::KEY_NONE, LEVEL_MAX);
        repeat (4) send_item(sgpc_pkg::KEY_NONE, -LEVEL_MAX);
        // unscaled threshold edges, ignored key, scaled edges
        send_item(sgpc_pkg::KEY_SCALE, 2000);
        send_item(sgpc_pkg::KEY_NONE, 2001);
        send_item(sgpc_pkg::KEY_NONE, 500);
        send_item(sgpc_pkg::KEY_NONE, 499);
        send_item(sgpc_pkg::KEY_IGNORE, 1000);
        send_item(sgpc_pkg::KEY_SCALE, 1274);
        send_item(sgpc_pkg::KEY_NONE, -1);
        // fine and narrow loops, then mode wrap
        send_item(sgpc_pkg::KEY_MODE, 0);
        send_item(sgpc_pkg::KEY_NONE, LEVEL_MAX);
        send_item(sgpc_pkg::KEY_NONE, 637);
        send_item(sgpc_pkg::KEY_MODE, -LEVEL_MAX);
        send_item(sgpc_pkg::KEY_NONE, 318);
        send_item(sgpc_pkg::KEY_MODE, LEVEL_MAX);
        send_item(sgpc_pkg::KEY_SCALE, -LEVEL_MAX);
        send_item(sgpc_pkg::KEY_SCALE, 0);

        // index past the last register must leave all registers alone
        drain_results();
        write_reg(CFG_SPARE_LO, 13'h1FFF);
        write_reg(CFG_SPARE_HI, 0);
        set_thresholds(int'(sgpc_pkg::LADDER_HIGH_RST), int'(sgpc_pkg::LADDER_LOW_RST),
                       int'(sgpc_pkg::FINE_REF_RST), int'(sgpc_pkg::FINE_BAND_RST),
                       int'(sgpc_pkg::NARROW_REF_RST), int'(sgpc_pkg::NARROW_BAND_RST));
        run_phase(60);
        // long run high in a fine or narrow loop walks the wiper down to its floor
        while (mode_seen == sgpc_pkg::MODE_LADDER) send_item(sgpc_pkg::KEY_MODE, 0);
        repeat (120) send_item(sgpc_pkg::KEY_NONE, LEVEL_MAX);

        set_thresholds(0, 0, 0, 0, 0, 0);
        run_phase(60);
        set_thresholds(8191, 8191, 8191, 8191, 8191, 8191);
        run_phase(60);
        set_thresholds($urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 8191), $urandom_range(0, 8191));
        run_phase(60);
        set_thresholds($urandom_range(1000, 6000), $urandom_range(0, 3000),
                       $urandom_range(0, 6000), $urandom_range(0, 20),
                       $urandom_range(0, 6000), $urandom_range(0, 20));
        run_phase(60);

        drain_results();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/sgpc_pkg.sv
sv/sgpc_cfg.sv
sv/sgpc_step.sv
sv/stepped_gain_pot_controller_top.sv
tb/stepped_gain_pot_controller_checker.sv
tb/stepped_gain_pot_controller_top_tb.sv
